// ===== rtl/dcp_pkg.sv =====
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants of the descriptor disk command port.
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

  localparam int NumSlots        = 16;
  localparam int SlotW           = $clog2(NumSlots);
  localparam int SectorsPerTrack = 26;
  localparam int QueueDepth      = 2;

  localparam int DataW = 48;

  localparam logic [7:0] SlotSelectBit = 8'h10;

  // unit code to drive number plus one, zero when the code selects no drive
  localparam logic [2:0] UnitToCode [16] = '{
    3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd0, 3'd0, 3'd0,
    3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  typedef enum logic [1:0] {
    CMD_PORT_READ  = 2'd0,
    CMD_PORT_WRITE = 2'd1,
    CMD_DESC       = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ_DATA = 2'd0,
    KIND_FETCH     = 2'd1,
    KIND_TRANSFER  = 2'd2,
    KIND_STATUS    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    XOP_FORMAT = 2'd0,
    XOP_READ   = 2'd1,
    XOP_WRITE  = 2'd2
  } xfer_op_e;

  typedef enum logic [1:0] {
    STATUS_ILLEGAL    = 2'd0,
    STATUS_DONE       = 2'd1,
    STATUS_UNATTACHED = 2'd2
  } status_e;

  // one classified item: an optional transfer word, then a final word
  typedef struct packed {
    kind_e       final_kind;
    logic [15:0] final_addr;
    status_e     status;
    logic        has_xfer;
    logic [15:0] xfer_addr;
    logic [1:0]  drive;
    xfer_op_e    xfer_op;
    logic [12:0] first_sector;
    logic [4:0]  sector_count;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/dcp_front.sv =====
// ----------------------------------------------------------------------------
// dcp_front
// Accepts input words, keeps the slot table and port state, and turns each
// word that needs an answer into a job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_valid_i,
  output logic                         s_ready_o,
  input  wire logic [1:0]              s_user_i,
  input  wire logic [dcp_pkg::DataW-1:0] s_data_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [3:0]              cfg_wdata_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output dcp_pkg::job_t                q_job_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_e;

  localparam logic [3:0] DescOpWrite  = 4'd1;
  localparam logic [3:0] DescOpRead   = 4'd2;
  localparam logic [3:0] DescOpFormat = 4'd3;

  phase_e                       phase_q, phase_d;
  logic [dcp_pkg::SlotW-1:0]    sel_q, sel_d;
  logic [15:0]                  slot_addr_q [dcp_pkg::NumSlots];
  logic [15:0]                  slot_addr_d [dcp_pkg::NumSlots];
  logic [15:0]                  pend_q, pend_d;
  logic                         await_q, await_d;
  logic [3:0]                   attached_q;

  logic                         accept;
  dcp_pkg::cmd_e                cmd;
  logic [7:0]                   port_data, op_unit, track, sector;
  logic [15:0]                  buf_addr;
  logic [3:0]                   desc_op;
  logic [2:0]                   code;
  logic [1:0]                   drive;
  logic [12:0]                  base, sum;
  dcp_pkg::job_t                job;
  logic                         push;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign cmd       = dcp_pkg::cmd_e'(s_user_i);

  assign port_data = s_data_i[7:0];
  assign op_unit   = s_data_i[15:8];
  assign track     = s_data_i[23:16];
  assign sector    = s_data_i[31:24];
  assign buf_addr  = s_data_i[47:32];

  assign desc_op = op_unit[7:4];
  assign code    = dcp_pkg::UnitToCode[op_unit[3:0]];
  assign drive   = 2'(code - 3'd1);
  assign base    = 13'(track) * 13'(dcp_pkg::SectorsPerTrack);
  assign sum     = base + 13'(sector);

  always_comb begin
    phase_d     = phase_q;
    sel_d       = sel_q;
    slot_addr_d = slot_addr_q;
    pend_d      = pend_q;
    await_d     = await_q;
    push        = 1'b0;
    job         = '0;
    job.final_kind = dcp_pkg::KIND_READ_DATA;
    job.status     = dcp_pkg::STATUS_ILLEGAL;
    job.xfer_op    = dcp_pkg::XOP_FORMAT;
    if (accept) begin
      unique case (cmd)
        dcp_pkg::CMD_PORT_READ: begin
          push = 1'b1;
        end
        dcp_pkg::CMD_PORT_WRITE: begin
          if (!await_q) begin
            priority if (phase_q == PH_LOW) begin
              slot_addr_d[sel_q] = {8'h00, port_data};
              phase_d = PH_HIGH;
            end else if (phase_q == PH_HIGH) begin
              slot_addr_d[sel_q] = {port_data, slot_addr_q[sel_q][7:0]};
              phase_d = PH_IDLE;
            end else begin
              sel_d = port_data[dcp_pkg::SlotW-1:0];
              if ((port_data & dcp_pkg::SlotSelectBit) != 8'h00) begin
                phase_d = PH_LOW;
              end else begin
                phase_d        = PH_IDLE;
                pend_d         = slot_addr_q[port_data[dcp_pkg::SlotW-1:0]];
                await_d        = 1'b1;
                push           = 1'b1;
                job.final_kind = dcp_pkg::KIND_FETCH;
                job.final_addr = pend_d;
              end
            end
          end
        end
        dcp_pkg::CMD_DESC: begin
          if (await_q) begin
            await_d        = 1'b0;
            push           = 1'b1;
            job.final_kind = dcp_pkg::KIND_STATUS;
            job.final_addr = pend_q + 16'd1;
            if (code == 3'd0) begin
              job.status = dcp_pkg::STATUS_ILLEGAL;
            end else if (!attached_q[drive]) begin
              job.status = dcp_pkg::STATUS_UNATTACHED;
            end else begin
              job.status = dcp_pkg::STATUS_DONE;
              job.drive  = drive;
              if (desc_op == DescOpFormat) begin
                job.has_xfer     = 1'b1;
                job.xfer_op      = dcp_pkg::XOP_FORMAT;
                job.first_sector = base;
                job.sector_count = 5'(dcp_pkg::SectorsPerTrack);
              end else if (desc_op == DescOpWrite || desc_op == DescOpRead) begin
                // track 0 sector 0 lies before the disk start: no transfer
                job.has_xfer     = (sum != 13'd0);
                job.xfer_addr    = buf_addr;
                job.xfer_op      = (desc_op == DescOpRead) ? dcp_pkg::XOP_READ
                                                           : dcp_pkg::XOP_WRITE;
                job.first_sector = sum - 13'd1;
                job.sector_count = 5'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push_o = push;
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sel_q      <= '0;
      pend_q     <= '0;
      await_q    <= 1'b0;
      attached_q <= '0;
      for (int i = 0; i < dcp_pkg::NumSlots; i++) begin
        slot_addr_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      sel_q       <= sel_d;
      pend_q      <= pend_d;
      await_q     <= await_d;
      slot_addr_q <= slot_addr_d;
      if (cfg_we_i) begin
        attached_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcp_queue.sv =====
// ----------------------------------------------------------------------------
// dcp_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dcp_pkg::job_t push_job_i,
  output logic               full_o,
  output logic               valid_o,
  output dcp_pkg::job_t      head_o,
  input  wire logic          pop_i
);

  localparam int PtrW = (dcp_pkg::QueueDepth > 1) ? $clog2(dcp_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(dcp_pkg::QueueDepth + 1);

  dcp_pkg::job_t   mem_q [dcp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(dcp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(dcp_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(dcp_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcp_back.sv =====
// ----------------------------------------------------------------------------
// dcp_back
// Expands queued jobs into result words and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  input  wire dcp_pkg::job_t             q_job_i,
  output logic                           q_pop_o,
  output logic                           m_valid_o,
  input  wire logic                      m_ready_i,
  output logic [dcp_pkg::DataW-1:0]      m_data_o,
  output logic [1:0]                     m_user_o,
  output logic                           m_last_o
);

  logic                         valid_q, valid_d;
  logic [dcp_pkg::DataW-1:0]    data_q, data_d;
  dcp_pkg::kind_e               kind_q, kind_d;
  logic                         last_q, last_d;
  logic                         second_q, second_d;
  logic                         load, emit_xfer;

  assign load      = !valid_q || m_ready_i;
  // the transfer word goes out first, the final word on the next load
  assign emit_xfer = q_job_i.has_xfer && !second_q;
  assign q_pop_o   = load && q_valid_i && !emit_xfer;

  always_comb begin
    valid_d  = valid_q;
    data_d   = data_q;
    kind_d   = kind_q;
    last_d   = last_q;
    second_d = second_q;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        if (emit_xfer) begin
          kind_d   = dcp_pkg::KIND_TRANSFER;
          last_d   = 1'b0;
          second_d = 1'b1;
          data_d   = {2'b00, q_job_i.sector_count, q_job_i.first_sector,
                      q_job_i.xfer_op, q_job_i.drive, q_job_i.xfer_addr, 8'h00};
        end else begin
          kind_d   = q_job_i.final_kind;
          last_d   = 1'b1;
          second_d = 1'b0;
          data_d   = {q_job_i.status, 5'd0, 13'd0, 2'd0, 2'd0,
                      q_job_i.final_addr, 8'h00};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
      kind_q   <= dcp_pkg::KIND_READ_DATA;
      last_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
      kind_q   <= kind_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = kind_q;
  assign m_last_o  = last_q;

  a_second_has_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (q_valid_i && q_job_i.has_xfer))
    else $error("second word pending without a transfer job");

  a_xfer_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == dcp_pkg::KIND_TRANSFER) |-> !last_q)
    else $error("transfer word marked last");

  a_final_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != dcp_pkg::KIND_TRANSFER) |-> last_q)
    else $error("final word not marked last");

  a_xfer_then_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && m_ready_i && kind_q == dcp_pkg::KIND_TRANSFER)
      |=> (valid_q && kind_q == dcp_pkg::KIND_STATUS))
    else $error("transfer word not followed by its status word");

endmodule

`default_nettype wire

// ===== rtl/descriptor_disk_command_port.sv =====
// ----------------------------------------------------------------------------
// descriptor_disk_command_port
// Descriptor driven disk command port: slot table, fetch and transfer issue.
// ----------------------------------------------------------------------------
// Input words (s_axis): tuser carries the command (port read, port write,
// descriptor arrival), tdata the port byte and the fetched descriptor.
// Output words (m_axis): tuser carries the word kind (read data, descriptor
// fetch, disk transfer, status store), tlast marks the final word of an input.
// cfg_we_i writes the attached drive mask; write it only while idle.
// A front stage decodes each word in its accept cycle and queues a job in a
// two entry queue; a back stage expands jobs into words in the output
// register. One input word per cycle is sustained while the receiver
// takes every word and the queue has room; a descriptor that issues a
// transfer yields two output words and so holds the back stage for both.
// Words that cause no output (slot loads, ignored writes) queue no job.
// Reset clears the slot table, port phase, pending descriptor and drive mask.
// When the receiver stalls, the output word holds, the queue fills and
// s_axis_tready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_disk_command_port (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] port_data, [15:8] desc_op_unit, [23:16] desc_track,
  // [31:24] desc_sector, [47:32] desc_buffer_address
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [23:8] mem_address, [25:24] drive, [27:26] transfer_op,
  // [40:28] first_sector, [45:41] sector_count, [47:46] status_value
  output logic [47:0]      m_axis_tdata,
  // [1:0] kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i
);

  logic          q_full, q_push, q_valid, q_pop;
  dcp_pkg::job_t push_job, head_job;

  dcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_user_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  dcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_job),
    .pop_i      (q_pop)
  );

  dcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (head_job),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
